// ----- rtl/core/mse_pkg.sv -----
// Shared types and constants for the multi-stack engine.
// Holds the status codes, operation codes, controller states and the command/status
// structs between the controller and the datapath. No dependencies.
package mse_pkg;

	localparam int COUNT_W  = 4;
	localparam int INDEX_W  = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int IUSER_W  = 1 + INDEX_W;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_READ = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic eval;
		logic grab;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rd_pend;
	} dp_stat_t;

endpackage

// ----- rtl/core/mse_ram.sv -----
// Generic single-port RAM with registered read data.
// Parameters give the word width and the depth. No dependencies.
module mse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ----- rtl/core/mse_ctrl.sv -----
// Controller state machine of the multi-stack engine.
// Sequences accept, evaluation, memory read and result hand-off. Depends on mse_pkg.
module mse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  mse_pkg::dp_stat_t    stat,
	output mse_pkg::ctrl_cmd_t   cmd
);

	import mse_pkg::*;

	state_t state_q;
	state_t state_nxt;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);

	assign cmd.load = s_tvalid && (state_q == S_IDLE);
	assign cmd.eval = (state_q == S_EVAL);
	assign cmd.grab = (state_q == S_READ);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_nxt = S_EVAL;
				end
			end
			S_EVAL: begin
				// A successful pop waits in S_READ for the registered memory word.
				state_nxt = stat.rd_pend ? S_READ : S_OUT;
			end
			S_READ: begin
				state_nxt = S_OUT;
			end
			S_OUT: begin
				if (m_tready) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- rtl/core/mse_datapath.sv -----
// Datapath of the multi-stack engine: count and capacity registers, fill counters,
// item and result registers, and the shared stack memory.
// Depends on mse_pkg and mse_ram.
module mse_datapath #(
	parameter int MEMORY_DEPTH = 128,
	parameter int MAX_STACKS   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mse_pkg::COUNT_W-1:0]   cfg_wdata,
	input  logic [mse_pkg::VALUE_W-1:0]   s_tdata,
	input  logic [mse_pkg::IUSER_W-1:0]   s_tuser,
	output logic [mse_pkg::VALUE_W-1:0]   m_tdata,
	output logic [mse_pkg::STATUS_W-1:0]  m_tuser,
	input  mse_pkg::ctrl_cmd_t            cmd,
	output mse_pkg::dp_stat_t             stat
);

	import mse_pkg::*;

	localparam int FILL_W  = $clog2(MEMORY_DEPTH + 1);
	localparam int ADDR_W  = $clog2(MEMORY_DEPTH);
	localparam int PROD_W  = FILL_W + INDEX_W;
	localparam int NIDX    = 1 << INDEX_W;
	localparam int NCODE   = 1 << COUNT_W;
	localparam int CNT_LIM = (MAX_STACKS < NCODE - 1) ? MAX_STACKS : NCODE - 1;

	// Capacity for every possible count code, worked out at elaboration.
	logic [FILL_W-1:0] cap_tab [NCODE];

	for (genvar k = 0; k < NCODE; k++) begin : g_cap
		localparam int DIV = (k == 0) ? 1 : k;
		assign cap_tab[k] = FILL_W'(MEMORY_DEPTH / DIV);
	end

	logic [COUNT_W-1:0]  count_q;
	logic [FILL_W-1:0]   cap_q;
	logic [FILL_W-1:0]   fill_q [NIDX];

	logic                mode_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [VALUE_W-1:0]  val_q;

	status_t             status_q;
	logic [VALUE_W-1:0]  pop_val_q;

	logic [COUNT_W-1:0]  count_new;
	logic                idx_ok;
	logic [FILL_W-1:0]   fill;
	logic                push_ok;
	logic                pop_ok;
	logic [FILL_W-1:0]   offset;
	logic [PROD_W-1:0]   base;
	logic [PROD_W-1:0]   addr_full;
	logic [ADDR_W-1:0]   addr;
	logic                mem_we;
	logic                mem_re;
	logic [VALUE_W-1:0]  mem_rdata;
	status_t             status;

	// Saturate the written count into 1..CNT_LIM.
	always_comb begin
		count_new = cfg_wdata;
		if (cfg_wdata == '0) begin
			count_new = COUNT_W'(1);
		end else if (cfg_wdata > COUNT_W'(CNT_LIM)) begin
			count_new = COUNT_W'(CNT_LIM);
		end
	end

	assign idx_ok  = (COUNT_W'(idx_q) < count_q) && (32'(idx_q) < MAX_STACKS);
	assign fill    = fill_q[idx_q];
	assign push_ok = (fill < cap_q);
	assign pop_ok  = (fill != '0);

	assign offset    = (mode_q == MODE_POP) ? fill - FILL_W'(1) : fill;
	assign base      = PROD_W'(idx_q) * PROD_W'(cap_q);
	assign addr_full = base + PROD_W'(offset);
	assign addr      = addr_full[ADDR_W-1:0];

	assign mem_we = cmd.eval && idx_ok && (mode_q == MODE_PUSH) && push_ok;
	assign mem_re = cmd.eval && idx_ok && (mode_q == MODE_POP) && pop_ok;

	assign stat.rd_pend = idx_ok && (mode_q == MODE_POP) && pop_ok;

	always_comb begin
		priority if (!idx_ok) begin
			status = ST_BAD_INDEX;
		end else if (mode_q == MODE_PUSH) begin
			status = push_ok ? ST_OK : ST_OVERFLOW;
		end else begin
			status = pop_ok ? ST_OK : ST_UNDERFLOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_W'(1);
			cap_q   <= FILL_W'(MEMORY_DEPTH);
			for (int i = 0; i < NIDX; i++) begin
				fill_q[i] <= '0;
			end
		end else if (cfg_we) begin
			// A new count empties every stack.
			count_q <= count_new;
			cap_q   <= cap_tab[count_new];
			for (int i = 0; i < NIDX; i++) begin
				fill_q[i] <= '0;
			end
		end else if (mem_we) begin
			fill_q[idx_q] <= fill + FILL_W'(1);
		end else if (mem_re) begin
			fill_q[idx_q] <= fill - FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= s_tuser[0];
			idx_q  <= s_tuser[IUSER_W-1:1];
			val_q  <= s_tdata;
		end
		if (cmd.eval) begin
			status_q  <= status;
			pop_val_q <= '0;
		end
		if (cmd.grab) begin
			pop_val_q <= mem_rdata;
		end
	end

	assign m_tuser = status_q;
	assign m_tdata = pop_val_q;

	mse_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MEMORY_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (addr),
		.wdata (val_q),
		.rdata (mem_rdata)
	);

endmodule

// ----- rtl/core/multi_stack_engine_core.sv -----
// Multi-stack engine: equal LIFO stacks sharing one memory, one push or pop per beat.
// A result is presented after the S_EVAL state, and a pop that succeeds also passes through
// S_READ, because the memory read data is registered. The controller takes the next
// beat only once the result has been taken, so one item is in flight at a time.
// Reset is asynchronous: count 1, capacity the whole memory, every stack empty.
module multi_stack_engine_core #(
	parameter int MEMORY_DEPTH = 128,
	parameter int MAX_STACKS   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mse_pkg::COUNT_W-1:0]   cfg_wdata,  // stack_count
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mse_pkg::VALUE_W-1:0]   s_tdata,    // push_value
	input  logic [mse_pkg::IUSER_W-1:0]   s_tuser,    // mode, stack_index
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mse_pkg::VALUE_W-1:0]   m_tdata,    // pop_value
	output logic [mse_pkg::STATUS_W-1:0]  m_tuser     // status
);

	import mse_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	mse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mse_datapath #(
		.MEMORY_DEPTH (MEMORY_DEPTH),
		.MAX_STACKS   (MAX_STACKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ----- rtl/core/mse_checker.sv -----
// Port-level checks for the multi-stack engine, bound to the top level.
// Depends on mse_pkg and multi_stack_engine_core.
module mse_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [mse_pkg::COUNT_W-1:0]   cfg_wdata,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [mse_pkg::VALUE_W-1:0]   s_tdata,
	input logic [mse_pkg::IUSER_W-1:0]   s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mse_pkg::VALUE_W-1:0]   m_tdata,
	input logic [mse_pkg::STATUS_W-1:0]  m_tuser
);

	import mse_pkg::*;

	// Only one item is in flight, so the block never takes a beat while a result waits.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
		else $error("engine not busy after an input beat");

	a_idle_after_output: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> s_tready)
		else $error("engine not ready after the result beat");

	// Every result other than a successful operation carries a zero value.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
		else $error("failed operation returned a non-zero value");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result beat changed");

endmodule

bind multi_stack_engine_core mse_checker u_mse_checker (.*);
